[hw/rtl/arow_online_classifier_unit_macros.svh]
// ----------------------------------------------------------------------------
// AROW classifier assertion macros
// Shared concurrent assertion forms used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef AROW_ONLINE_CLASSIFIER_UNIT_MACROS_SVH
`define AROW_ONLINE_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AROW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arow assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AROW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arow assertion failed");

`endif

[hw/rtl/arow_pkg.sv]
// ----------------------------------------------------------------------------
// AROW classifier package
// Shared widths, sequencer states and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package arow_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 7;
  localparam int CNT_W  = 32;
  localparam logic [DATA_W-1:0] REG_RESET = 32'd65536;

  typedef enum logic [5:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_M_RDBUF,
    ST_M_RDW,
    ST_M_MUL,
    ST_M_ACC,
    ST_M_DONE,
    ST_LOSS,
    ST_LCHK,
    ST_X_RDBUF,
    ST_X_RDC,
    ST_X_MUL,
    ST_X_ACC,
    ST_X_WR,
    ST_Q_RDBUF,
    ST_Q_RDS,
    ST_Q_MUL,
    ST_Q_ACC,
    ST_Q_DONE,
    ST_DIVSTART,
    ST_DIVCHK,
    ST_DIV,
    ST_BETA,
    ST_A_MUL,
    ST_A_SAT,
    ST_W_RD,
    ST_W_MUL,
    ST_W_WR,
    ST_C_RDI,
    ST_C_LATI,
    ST_C_RDJ,
    ST_C_MUL1,
    ST_C_SAT,
    ST_C_MUL2,
    ST_C_WR,
    ST_FIN
  } arow_state_t;

  typedef struct packed {
    arow_state_t op;
    logic        in_take;
    logic        load_out;
  } arow_cmd_t;

  typedef struct packed {
    logic nz;
    logic e_last;
    logic i_last;
    logic j_last;
    logic loss_pos;
    logic den_pos;
    logic div_done;
  } arow_stat_t;

endpackage

`default_nettype wire

[hw/rtl/arow_ram.sv]
// ----------------------------------------------------------------------------
// AROW generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module arow_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/arow_ctrl.sv]
// ----------------------------------------------------------------------------
// AROW controller
// Sequencer for the clearing pass, the per-example loops and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arow_online_classifier_unit_macros.svh"

module arow_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last_feature,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire arow_pkg::arow_stat_t st,
  output arow_pkg::arow_cmd_t       cmd
);

  import arow_pkg::*;

  arow_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (st.i_last && st.j_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid && in_last_feature) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = st.nz ? ST_M_RDBUF : ST_FIN;
      ST_M_RDBUF:  state_nxt = ST_M_RDW;
      ST_M_RDW:    state_nxt = ST_M_MUL;
      ST_M_MUL:    state_nxt = ST_M_ACC;
      ST_M_ACC:    state_nxt = st.e_last ? ST_M_DONE : ST_M_RDBUF;
      ST_M_DONE:   state_nxt = ST_LOSS;
      ST_LOSS:     state_nxt = ST_LCHK;
      ST_LCHK:     state_nxt = st.loss_pos ? ST_X_RDBUF : ST_FIN;
      ST_X_RDBUF:  state_nxt = ST_X_RDC;
      ST_X_RDC:    state_nxt = ST_X_MUL;
      ST_X_MUL:    state_nxt = ST_X_ACC;
      ST_X_ACC:    state_nxt = st.e_last ? ST_X_WR : ST_X_RDBUF;
      ST_X_WR:     state_nxt = st.i_last ? ST_Q_RDBUF : ST_X_RDBUF;
      ST_Q_RDBUF:  state_nxt = ST_Q_RDS;
      ST_Q_RDS:    state_nxt = ST_Q_MUL;
      ST_Q_MUL:    state_nxt = ST_Q_ACC;
      ST_Q_ACC:    state_nxt = st.e_last ? ST_Q_DONE : ST_Q_RDBUF;
      ST_Q_DONE:   state_nxt = ST_DIVSTART;
      ST_DIVSTART: state_nxt = ST_DIVCHK;
      ST_DIVCHK:   state_nxt = st.den_pos ? ST_DIV : ST_BETA;
      ST_DIV:      if (st.div_done) state_nxt = ST_BETA;
      ST_BETA:     state_nxt = ST_A_MUL;
      ST_A_MUL:    state_nxt = ST_A_SAT;
      ST_A_SAT:    state_nxt = ST_W_RD;
      ST_W_RD:     state_nxt = ST_W_MUL;
      ST_W_MUL:    state_nxt = ST_W_WR;
      ST_W_WR:     state_nxt = st.i_last ? ST_C_RDI : ST_W_RD;
      ST_C_RDI:    state_nxt = ST_C_LATI;
      ST_C_LATI:   state_nxt = ST_C_RDJ;
      ST_C_RDJ:    state_nxt = ST_C_MUL1;
      ST_C_MUL1:   state_nxt = ST_C_SAT;
      ST_C_SAT:    state_nxt = ST_C_MUL2;
      ST_C_MUL2:   state_nxt = ST_C_WR;
      ST_C_WR: begin
        if (!st.j_last) state_nxt = ST_C_RDJ;
        else if (!st.i_last) state_nxt = ST_C_RDI;
        else state_nxt = ST_FIN;
      end
      ST_FIN:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = state_r;
    cmd.in_take  = (state_r == ST_IDLE) && in_valid;
    cmd.load_out = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
    in_stall     = (state_r != ST_IDLE);
    out_valid    = out_valid_r;
    // a fresh load wins over the drain of the previous result
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `AROW_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load_out, !out_valid_r || !out_stall)
  `AROW_ASSERT_NEXT(a_last_check, clk, rst_n, cmd.in_take && in_last_feature, state_r == ST_CHECK)
  `AROW_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid_r)

endmodule

`default_nettype wire

[hw/rtl/arow_dpath.sv]
// ----------------------------------------------------------------------------
// AROW datapath
// Buffers, model memories, shared multiplier, accumulator and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module arow_dpath #(
  parameter int DIM       = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire arow_pkg::arow_cmd_t         cmd,
  output arow_pkg::arow_stat_t             st,
  input  wire logic [arow_pkg::IDX_W-1:0]  in_feature_index,
  input  wire logic signed [arow_pkg::DATA_W-1:0] in_feature_value,
  input  wire logic                        in_label_positive,
  input  wire logic                        cfg_wr_en,
  input  wire logic [arow_pkg::DATA_W-1:0] cfg_wr_data,
  output logic                             out_predicted_positive,
  output logic signed [arow_pkg::DATA_W-1:0] out_margin,
  output logic                             out_skipped,
  output logic                             out_updated,
  output logic [arow_pkg::CNT_W-1:0]       out_true_pos_count,
  output logic [arow_pkg::CNT_W-1:0]       out_true_neg_count,
  output logic [arow_pkg::CNT_W-1:0]       out_false_pos_count,
  output logic [arow_pkg::CNT_W-1:0]       out_false_neg_count,
  output logic [arow_pkg::CNT_W-1:0]       out_query_count
);

  import arow_pkg::*;

  localparam int AW    = $clog2(DIM);
  localparam int FW    = $clog2(DIM + 1);
  localparam int CW    = $clog2(DIM * DIM);
  localparam int PSW   = 64 - FRAC_BITS;
  localparam int ACC_W = PSW + AW + 1;
  localparam int SW    = (ACC_W > 67) ? ACC_W : 67;
  localparam int NB    = 2 * FRAC_BITS + 1;
  localparam int QW    = (NB > 32) ? NB : 32;
  localparam int DCW   = $clog2(NB);
  localparam int DENW  = 34;
  localparam logic signed [31:0] ONE_Q = 32'sh1 << FRAC_BITS;
  localparam logic signed [31:0] SMAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SMIN  = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > SW'(SMAX)) begin
      return SMAX;
    end else if (v < SW'(SMIN)) begin
      return SMIN;
    end
    return v[31:0];
  endfunction

  // loop counters and example state
  logic [AW-1:0]   e_r, e_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic            nz_r, nz_nxt, upd_r, upd_nxt;
  logic [31:0]     r_r, r_nxt;
  logic [CNT_W-1:0] tp_r, tp_nxt, tn_r, tn_nxt, fp_r, fp_nxt, fn_r, fn_nxt;
  logic [CNT_W-1:0] qc_r, qc_nxt;
  logic [DCW-1:0]  dc_r, dc_nxt;

  // working payload
  logic                    ypos_r, ypos_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [63:0]      prod_r, prod_nxt;
  logic signed [31:0]      val_r, val_nxt, margin_r, margin_nxt, loss_r, loss_nxt;
  logic signed [31:0]      xsx_r, xsx_nxt, beta_r, beta_nxt, alpha_r, alpha_nxt;
  logic signed [31:0]      sxi_r, sxi_nxt, u_r, u_nxt;
  logic [DENW-1:0]         den_r, den_nxt, rem_r, rem_nxt;
  logic [QW-1:0]           q_r, q_nxt;

  // memory ports
  logic          buf_we, buf_re, w_we, w_re, sx_we, sx_re, cov_we, cov_re;
  logic [AW-1:0] buf_rd_idx, w_waddr, w_raddr, sx_waddr, sx_raddr;
  logic [31:0]   buf_rd_val, w_wdata, w_rd, sx_wdata, sx_rd, cov_wdata, cov_rd;
  logic [CW-1:0] cov_waddr, cov_raddr, cov_ij, cov_ib;

  // input index conversion
  logic [IDX_W-1:0] idx_m1;
  logic [AW+6:0]    idx_ext;
  logic [AW-1:0]    idx_wr;
  logic             idx_ok;

  logic signed [31:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [63:0] prod_sh;
  logic [DENW:0]      trial;

  assign idx_m1  = in_feature_index - IDX_W'(1);
  assign idx_ext = (AW + 7)'(idx_m1);
  assign idx_wr  = idx_ext[AW-1:0];
  assign idx_ok  = (in_feature_index != '0) && (32'(in_feature_index) <= 32'(DIM));
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign cov_ij  = CW'(i_r) * CW'(DIM) + CW'(j_r);
  assign cov_ib  = CW'(i_r) * CW'(DIM) + CW'(buf_rd_idx);
  assign trial   = {rem_r, (dc_r == DCW'(NB - 1))};

  always_comb begin
    st.nz       = nz_r;
    st.e_last   = ((FW + 1)'(e_r) + (FW + 1)'(1)) == (FW + 1)'(fill_r);
    st.i_last   = (i_r == AW'(DIM - 1));
    st.j_last   = (j_r == AW'(DIM - 1));
    st.loss_pos = !loss_r[31] && (loss_r != '0);
    st.den_pos  = !den_r[DENW-1] && (den_r != '0);
    st.div_done = (dc_r == '0);
  end

  always_comb begin
    e_nxt = e_r; i_nxt = i_r; j_nxt = j_r;
    fill_nxt = fill_r; nz_nxt = nz_r; upd_nxt = upd_r;
    r_nxt = cfg_wr_en ? cfg_wr_data : r_r;
    tp_nxt = tp_r; tn_nxt = tn_r; fp_nxt = fp_r; fn_nxt = fn_r; qc_nxt = qc_r;
    dc_nxt = dc_r;
    ypos_nxt = ypos_r; acc_nxt = acc_r; val_nxt = val_r; margin_nxt = margin_r;
    loss_nxt = loss_r; xsx_nxt = xsx_r; beta_nxt = beta_r; alpha_nxt = alpha_r;
    sxi_nxt = sxi_r; u_nxt = u_r; den_nxt = den_r; rem_nxt = rem_r; q_nxt = q_r;
    buf_we = 1'b0; buf_re = 1'b0; w_we = 1'b0; w_re = 1'b0;
    sx_we = 1'b0; sx_re = 1'b0; cov_we = 1'b0; cov_re = 1'b0;
    w_waddr = i_r; w_raddr = i_r; sx_waddr = i_r; sx_raddr = i_r;
    cov_waddr = cov_ij; cov_raddr = cov_ij;
    w_wdata = '0; sx_wdata = sat32(SW'(acc_r)); cov_wdata = '0;
    mul_en = 1'b0; mul_a = val_r; mul_b = val_r;

    case (cmd.op)
      ST_CLEAR: begin
        cov_we    = 1'b1;
        cov_wdata = (i_r == j_r) ? ONE_Q : '0;
        w_we      = (i_r == '0);
        w_waddr   = j_r;
        j_nxt     = st.j_last ? '0 : j_r + AW'(1);
        if (st.j_last) i_nxt = st.i_last ? '0 : i_r + AW'(1);
      end
      ST_IDLE: begin
        if (cmd.in_take) begin
          ypos_nxt = in_label_positive;
          if (idx_ok && (fill_r < FW'(DIM))) begin
            buf_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
            if (in_feature_value != '0) nz_nxt = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        e_nxt   = '0;
        acc_nxt = '0;
      end
      ST_M_RDBUF, ST_X_RDBUF, ST_Q_RDBUF: buf_re = 1'b1;
      ST_M_RDW: begin
        w_re    = 1'b1;
        w_raddr = buf_rd_idx;
        val_nxt = buf_rd_val;
      end
      ST_X_RDC: begin
        cov_re    = 1'b1;
        cov_raddr = cov_ib;
        val_nxt   = buf_rd_val;
      end
      ST_Q_RDS: begin
        sx_re    = 1'b1;
        sx_raddr = buf_rd_idx;
        val_nxt  = buf_rd_val;
      end
      ST_M_MUL: begin
        mul_en = 1'b1;
        mul_a  = w_rd;
      end
      ST_X_MUL: begin
        mul_en = 1'b1;
        mul_a  = cov_rd;
      end
      ST_Q_MUL: begin
        mul_en = 1'b1;
        mul_a  = sx_rd;
      end
      ST_M_ACC, ST_X_ACC, ST_Q_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_sh);
        e_nxt   = st.e_last ? '0 : e_r + AW'(1);
      end
      ST_M_DONE: margin_nxt = sat32(SW'(acc_r));
      ST_LOSS: begin
        loss_nxt = ypos_r ? sat32(SW'(ONE_Q) - SW'(margin_r))
                          : sat32(SW'(ONE_Q) + SW'(margin_r));
        if ((!margin_r[31]) == ypos_r) begin
          if (ypos_r) tp_nxt = tp_r + CNT_W'(1);
          else tn_nxt = tn_r + CNT_W'(1);
        end else begin
          if (!margin_r[31]) fp_nxt = fp_r + CNT_W'(1);
          else fn_nxt = fn_r + CNT_W'(1);
        end
        qc_nxt = qc_r + CNT_W'(1);
      end
      ST_LCHK: begin
        if (st.loss_pos) upd_nxt = 1'b1;
        i_nxt   = '0;
        e_nxt   = '0;
        acc_nxt = '0;
      end
      ST_X_WR: begin
        sx_we   = 1'b1;
        acc_nxt = '0;
        i_nxt   = st.i_last ? '0 : i_r + AW'(1);
      end
      ST_Q_DONE: xsx_nxt = sat32(SW'(acc_r));
      ST_DIVSTART: begin
        den_nxt = DENW'(xsx_r) + DENW'(r_r);
        rem_nxt = '0;
        q_nxt   = '0;
        dc_nxt  = DCW'(NB - 1);
      end
      ST_DIV: begin
        // restoring step: numerator is a single one bit at the top
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = DENW'(trial - {1'b0, den_r});
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DENW-1:0];
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        dc_nxt = dc_r - DCW'(1);
      end
      ST_BETA: beta_nxt = (q_r > QW'(SMAX)) ? SMAX : q_r[31:0];
      ST_A_MUL: begin
        mul_en = 1'b1;
        mul_a  = loss_r;
        mul_b  = beta_r;
      end
      ST_A_SAT: alpha_nxt = sat32(SW'(prod_sh));
      ST_W_RD: begin
        w_re  = 1'b1;
        sx_re = 1'b1;
      end
      ST_W_MUL: begin
        mul_en = 1'b1;
        mul_a  = alpha_r;
        mul_b  = sx_rd;
      end
      ST_W_WR: begin
        w_we    = 1'b1;
        w_wdata = ypos_r ? sat32(SW'($signed(w_rd)) + SW'(prod_sh))
                         : sat32(SW'($signed(w_rd)) - SW'(prod_sh));
        i_nxt   = st.i_last ? '0 : i_r + AW'(1);
        j_nxt   = '0;
      end
      ST_C_RDI: sx_re = 1'b1;
      ST_C_LATI: sxi_nxt = sx_rd;
      ST_C_RDJ: begin
        sx_re    = 1'b1;
        sx_raddr = j_r;
        cov_re   = 1'b1;
      end
      ST_C_MUL1: begin
        mul_en = 1'b1;
        mul_a  = sxi_r;
        mul_b  = sx_rd;
      end
      ST_C_SAT: u_nxt = sat32(SW'(prod_sh));
      ST_C_MUL2: begin
        mul_en = 1'b1;
        mul_a  = beta_r;
        mul_b  = u_r;
      end
      ST_C_WR: begin
        cov_we    = 1'b1;
        cov_wdata = sat32(SW'($signed(cov_rd)) - SW'(prod_sh));
        j_nxt     = st.j_last ? '0 : j_r + AW'(1);
        if (st.j_last) i_nxt = st.i_last ? '0 : i_r + AW'(1);
      end
      ST_FIN: begin
        if (cmd.load_out) begin
          fill_nxt = '0;
          nz_nxt   = 1'b0;
          upd_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
    prod_nxt = mul_en ? mul_a * mul_b : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r <= '0; i_r <= '0; j_r <= '0;
      fill_r <= '0; nz_r <= 1'b0; upd_r <= 1'b0;
      r_r <= REG_RESET;
      tp_r <= '0; tn_r <= '0; fp_r <= '0; fn_r <= '0; qc_r <= '0;
      dc_r <= '0;
    end else begin
      e_r <= e_nxt; i_r <= i_nxt; j_r <= j_nxt;
      fill_r <= fill_nxt; nz_r <= nz_nxt; upd_r <= upd_nxt;
      r_r <= r_nxt;
      tp_r <= tp_nxt; tn_r <= tn_nxt; fp_r <= fp_nxt; fn_r <= fn_nxt; qc_r <= qc_nxt;
      dc_r <= dc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ypos_r <= ypos_nxt; acc_r <= acc_nxt; prod_r <= prod_nxt; val_r <= val_nxt;
    margin_r <= margin_nxt; loss_r <= loss_nxt; xsx_r <= xsx_nxt;
    beta_r <= beta_nxt; alpha_r <= alpha_nxt; sxi_r <= sxi_nxt; u_r <= u_nxt;
    den_r <= den_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    // snapshot the result so the next example can run while it waits
    if (cmd.load_out) begin
      out_predicted_positive <= nz_r && !margin_r[31];
      out_margin             <= nz_r ? margin_r : '0;
      out_skipped            <= !nz_r;
      out_updated            <= upd_r;
      out_true_pos_count     <= tp_r;
      out_true_neg_count     <= tn_r;
      out_false_pos_count    <= fp_r;
      out_false_neg_count    <= fn_r;
      out_query_count        <= qc_r;
    end
  end

  arow_ram #(.WIDTH(AW), .DEPTH(DIM)) u_buf_idx (
    .clk(clk), .we(buf_we), .waddr(fill_r[AW-1:0]), .wdata(idx_wr),
    .re(buf_re), .raddr(e_r), .rdata(buf_rd_idx)
  );

  arow_ram #(.WIDTH(32), .DEPTH(DIM)) u_buf_val (
    .clk(clk), .we(buf_we), .waddr(fill_r[AW-1:0]), .wdata(in_feature_value),
    .re(buf_re), .raddr(e_r), .rdata(buf_rd_val)
  );

  arow_ram #(.WIDTH(32), .DEPTH(DIM)) u_weights (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rd)
  );

  arow_ram #(.WIDTH(32), .DEPTH(DIM)) u_sigma_x (
    .clk(clk), .we(sx_we), .waddr(sx_waddr), .wdata(sx_wdata),
    .re(sx_re), .raddr(sx_raddr), .rdata(sx_rd)
  );

  arow_ram #(.WIDTH(32), .DEPTH(DIM * DIM)) u_cov (
    .clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
    .re(cov_re), .raddr(cov_raddr), .rdata(cov_rd)
  );

endmodule

`default_nettype wire

[hw/rtl/arow_online_classifier_unit.sv]
// A non-final item is taken into the feature buffer while idle; a final item with n buffered
// features runs the margin and loss pass when any is nonzero, and when an update follows also
// the sigma-x, quadratic, divide, weight and covariance sweeps; the update time is set by the
// covariance sweep through the covariance RAM read and write ports and the shared multiplier.
// Reset: a clearing pass over all DIM*DIM covariance entries loads the identity and zero
// weights before the first item is taken; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// AROW online classifier unit
// Sparse-feature online binary linear classifier with covariance adaptation.
// ----------------------------------------------------------------------------
`default_nettype none

module arow_online_classifier_unit #(
  parameter int DIM       = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [arow_pkg::IDX_W-1:0]   in_feature_index,
  input  wire logic signed [arow_pkg::DATA_W-1:0] in_feature_value,
  input  wire logic                         in_label_positive,
  input  wire logic                         in_last_feature,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_predicted_positive,
  output logic signed [arow_pkg::DATA_W-1:0] out_margin,
  output logic                              out_skipped,
  output logic                              out_updated,
  output logic [arow_pkg::CNT_W-1:0]        out_true_pos_count,
  output logic [arow_pkg::CNT_W-1:0]        out_true_neg_count,
  output logic [arow_pkg::CNT_W-1:0]        out_false_pos_count,
  output logic [arow_pkg::CNT_W-1:0]        out_false_neg_count,
  output logic [arow_pkg::CNT_W-1:0]        out_query_count,
  input  wire logic                         cfg_wr_en,
  input  wire logic [arow_pkg::DATA_W-1:0]  cfg_wr_data
);

  import arow_pkg::*;

  arow_cmd_t  cmd;
  arow_stat_t st;

  arow_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_last_feature(in_last_feature), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .st(st), .cmd(cmd)
  );

  arow_dpath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_feature_index(in_feature_index), .in_feature_value(in_feature_value),
    .in_label_positive(in_label_positive),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_predicted_positive(out_predicted_positive), .out_margin(out_margin),
    .out_skipped(out_skipped), .out_updated(out_updated),
    .out_true_pos_count(out_true_pos_count), .out_true_neg_count(out_true_neg_count),
    .out_false_pos_count(out_false_pos_count), .out_false_neg_count(out_false_neg_count),
    .out_query_count(out_query_count)
  );

endmodule

`default_nettype wire
